/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the RTL files that check their own behaviour.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at each rising clock edge outside reset.
`define ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked at each rising clock edge outside reset.
`define ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* hw/rtl/erfd_pkg.sv */
`timescale 1ns / 1ps

package erfd_pkg;

  // Field and datapath widths.
  localparam int COUNT_W  = 16;
  localparam int SCALE_W  = 8;
  localparam int CONFIRM_W = 4;
  localparam int SAMPLE_W = 20;
  localparam int SHOW_W   = 10;
  localparam int SEG_W    = 8;
  localparam int DIGIT_W  = 4;
  localparam int RUN_W    = 4;

  // Shared divider: 24-bit dividend, 8-bit divisor.
  localparam int DIV_W    = 24;
  localparam int DEN_W    = 8;
  localparam int CNT_W    = $clog2(DIV_W + 1);
  localparam logic [CNT_W-1:0] STEPS_FULL  = CNT_W'(DIV_W);
  localparam logic [CNT_W-1:0] STEPS_DIGIT = CNT_W'(SHOW_W);

  // Constants of the behaviour.
  localparam logic [SHOW_W-1:0]   SHOW_MAX    = 10'd999;
  localparam logic [RUN_W-1:0]    RUN_MAX     = 4'd15;
  localparam logic [DEN_W-1:0]    HUNDRED     = 8'd100;
  localparam logic [DEN_W-1:0]    TEN         = 8'd10;
  localparam logic [SEG_W-1:0]    POINT_MASK  = 8'h7F;
  localparam logic [SCALE_W-1:0]  TICK_SCALE_RST = 8'd12;
  localparam logic [SCALE_W-1:0]  US_PER_CM_RST  = 8'd58;
  localparam logic [CONFIRM_W-1:0] CONFIRM_RST   = 4'd3;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_TICK_SCALE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_US_PER_CM     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CONFIRM_COUNT = 2'd2;

  typedef struct packed {
    logic [COUNT_W-1:0] echo_count;
    logic               echo_seen;
  } in_beat_t;

  typedef struct packed {
    logic [SHOW_W-1:0] distance_cm;
    logic [SEG_W-1:0]  seg_hundreds;
    logic [SEG_W-1:0]  seg_tens;
    logic [SEG_W-1:0]  seg_units;
  } out_beat_t;

  // Request to and response from the shared divider.
  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DEN_W-1:0] divisor;
    logic [CNT_W-1:0] steps;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
    logic [DEN_W-1:0] remainder;
  } div_rsp_t;

  // Active-low seven-segment code of one decimal digit.
  function automatic logic [SEG_W-1:0] seg_code(input logic [DIGIT_W-1:0] digit);
    logic [SEG_W-1:0] code;
    case (digit)
      4'd0:    code = 8'hC0;
      4'd1:    code = 8'hF9;
      4'd2:    code = 8'hA4;
      4'd3:    code = 8'hB0;
      4'd4:    code = 8'h99;
      4'd5:    code = 8'h92;
      4'd6:    code = 8'h82;
      4'd7:    code = 8'hF8;
      4'd8:    code = 8'h80;
      4'd9:    code = 8'h90;
      default: code = 8'hFF;
    endcase
    return code;
  endfunction

endpackage

/* hw/rtl/erfd_div.sv */
`timescale 1ns / 1ps

module erfd_div (
  input  logic                clk,
  input  logic                rst,
  input  erfd_pkg::div_req_t  req,
  output erfd_pkg::div_rsp_t  rsp
);
  import erfd_pkg::*;

  logic             busy;
  logic             done;
  logic [CNT_W-1:0] cnt;
  logic [DIV_W-1:0] dvd;
  logic [DIV_W-1:0] quo;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den;
  logic [DEN_W:0]   trial;
  logic             fits;
  logic             load;

  // One restoring step: bring down the next dividend bit and try a subtract.
  assign trial = {rem, dvd[DIV_W-1]};
  assign fits  = (trial >= {1'b0, den});
  assign load  = req.start && !busy;

  // Step counter; done is raised for one cycle after the last step.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == '0);
      if (load) begin
        busy <= 1'b1;
        cnt  <= req.steps - CNT_W'(1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
        end
        cnt <= cnt - CNT_W'(1);
      end
    end
  end

  // Operands are left-aligned so that only the requested number of bits is run.
  always_ff @(posedge clk) begin
    if (load) begin
      dvd <= req.dividend << (STEPS_FULL - req.steps);
      rem <= '0;
      quo <= '0;
      den <= req.divisor;
    end else if (busy) begin
      rem <= fits ? DEN_W'(trial - {1'b0, den}) : DEN_W'(trial);
      quo <= {quo[DIV_W-2:0], fits};
      dvd <= {dvd[DIV_W-2:0], 1'b0};
    end
  end

  assign rsp.done      = done;
  assign rsp.quotient  = quo;
  assign rsp.remainder = rem;

endmodule

/* hw/rtl/echo_range_filter_display.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Ultrasonic echo range filter with a three-digit display code output.
// Input channel (in_valid/in_ready/in_data): one beat per measurement, an echo
// timer count and an echo-seen flag. Config channel (cfg_valid/cfg_ready,
// cfg_index/cfg_data) is always ready; write it only while the block is idle.
// Output channel (out_valid/out_ready/out_data): one beat each time the shown
// distance changes, with the distance and its active-low segment codes.
// One item is worked on at a time; in_ready is low until it is finished.
// Every division runs through one shared restoring divider, one quotient bit
// per cycle: 24 steps per conversion or average, 10 steps per digit.
// A measurement is stored in the sample ring straight away without an echo, or
// after its conversion with one. The last of a group of SAMPLES adds a summing
// pass over the ring and the average division; a display update adds two digit
// divisions and the output load.
// A stalled receiver only holds back an item that has a new result to give;
// the output register holds its beat meanwhile and frees as it is taken.
// Synchronous reset clears the sample ring, the counters, the shown value,
// the output valid flag and returns the config registers to their defaults.
module echo_range_filter_display #(
  parameter int SAMPLES = 4
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  erfd_pkg::in_beat_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output erfd_pkg::out_beat_t                 out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [erfd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [erfd_pkg::SCALE_W-1:0]        cfg_data
);
  import erfd_pkg::*;

  localparam int SLOT_W = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
  localparam int SUM_W  = SAMPLE_W + $clog2(SAMPLES);
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(SAMPLES - 1);

  typedef enum logic [8:0] {
    S_IDLE    = 9'b000000001,
    S_MUL     = 9'b000000010,
    S_DIV_CM  = 9'b000000100,
    S_SUM     = 9'b000001000,
    S_AVG_GO  = 9'b000010000,
    S_DIV_AVG = 9'b000100000,
    S_DIV_HUN = 9'b001000000,
    S_DIV_TEN = 9'b010000000,
    S_OUT     = 9'b100000000
  } state_t;

  state_t                state;
  logic [SCALE_W-1:0]    tick_scale;
  logic [SCALE_W-1:0]    us_per_cm;
  logic [CONFIRM_W-1:0]  confirm_count;
  logic [COUNT_W-1:0]    echo_count;
  logic                  echo_seen;
  logic [SAMPLE_W-1:0]   sample_ring [SAMPLES];
  logic [SLOT_W-1:0]     sample_slot;
  logic [SLOT_W-1:0]     sum_idx;
  logic [SUM_W-1:0]      sum;
  logic [SHOW_W-1:0]     shown_distance;
  logic [RUN_W-1:0]      change_run;
  logic [DIGIT_W-1:0]    digit_hun;
  logic [DIGIT_W-1:0]    digit_ten;
  logic [DIGIT_W-1:0]    digit_unit;

  div_req_t              div_req;
  div_rsp_t              div_rsp;
  logic [DIV_W-1:0]      scaled;
  logic [SAMPLE_W-1:0]   sample_sat;
  logic [SHOW_W-1:0]     avg_sat;
  logic [RUN_W-1:0]      change_run_next;
  logic [CONFIRM_W-1:0]  need;
  logic                  show_new;
  logic                  store_en;
  logic [SAMPLE_W-1:0]   store_val;
  logic                  out_free;
  logic                  out_load;

  erfd_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || out_ready;
  assign out_load  = (state == S_OUT) && out_free;

  // Echo count times tick scale; the divider registers it on load.
  assign scaled = DIV_W'(echo_count) * DIV_W'(tick_scale);

  // Saturation of the converted sample and of the average.
  assign sample_sat = (|div_rsp.quotient[DIV_W-1:SAMPLE_W]) ? '1
                                                            : div_rsp.quotient[SAMPLE_W-1:0];
  assign avg_sat = (div_rsp.quotient > DIV_W'(SHOW_MAX)) ? SHOW_MAX
                                                         : div_rsp.quotient[SHOW_W-1:0];

  // Run of differing averages; a confirm count of zero behaves as one.
  assign change_run_next = (change_run == RUN_MAX) ? change_run : change_run + RUN_W'(1);
  assign need            = (confirm_count == '0) ? CONFIRM_W'(1) : confirm_count;
  assign show_new        = (avg_sat != shown_distance) && (change_run_next >= need);

  // A sample is stored straight away without an echo, else after the division.
  assign store_en  = ((state == S_MUL) && !echo_seen) ||
                     ((state == S_DIV_CM) && div_rsp.done);
  assign store_val = (state == S_MUL) ? '0 : sample_sat;

  // Operand selection for the shared divider.
  always_comb begin
    div_req = '0;
    unique case (state)
      S_MUL: begin
        div_req.start    = echo_seen;
        div_req.dividend = scaled;
        div_req.divisor  = us_per_cm;
        div_req.steps    = STEPS_FULL;
      end
      S_AVG_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = DIV_W'(sum);
        div_req.divisor  = DEN_W'(SAMPLES);
        div_req.steps    = STEPS_FULL;
      end
      S_DIV_AVG: begin
        div_req.start    = div_rsp.done && show_new;
        div_req.dividend = DIV_W'(avg_sat);
        div_req.divisor  = HUNDRED;
        div_req.steps    = STEPS_DIGIT;
      end
      S_DIV_HUN: begin
        div_req.start    = div_rsp.done;
        div_req.dividend = DIV_W'(div_rsp.remainder);
        div_req.divisor  = TEN;
        div_req.steps    = STEPS_DIGIT;
      end
      default: begin
        div_req = '0;
      end
    endcase
  end

  // Sequencer, sample ring, config registers and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      tick_scale     <= TICK_SCALE_RST;
      us_per_cm      <= US_PER_CM_RST;
      confirm_count  <= CONFIRM_RST;
      sample_slot    <= '0;
      sum_idx        <= '0;
      sum            <= '0;
      shown_distance <= '0;
      change_run     <= '0;
      out_valid      <= 1'b0;
      for (int k = 0; k < SAMPLES; k++) begin
        sample_ring[k] <= '0;
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_TICK_SCALE:    tick_scale    <= cfg_data;
          REG_US_PER_CM:     us_per_cm     <= cfg_data;
          REG_CONFIRM_COUNT: confirm_count <= cfg_data[CONFIRM_W-1:0];
          default: begin
          end
        endcase
      end

      // The output beat is loaded when the register is free, else freed once taken.
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            echo_count <= in_data.echo_count;
            echo_seen  <= in_data.echo_seen;
            state      <= S_MUL;
          end
        end
        S_MUL: begin
          if (echo_seen) begin
            state <= S_DIV_CM;
          end
        end
        S_DIV_CM: begin
        end
        S_SUM: begin
          sum     <= sum + SUM_W'(sample_ring[sum_idx]);
          sum_idx <= sum_idx + SLOT_W'(1);
          if (sum_idx == SLOT_LAST) begin
            state <= S_AVG_GO;
          end
        end
        S_AVG_GO: begin
          state <= S_DIV_AVG;
        end
        S_DIV_AVG: begin
          if (div_rsp.done) begin
            if (avg_sat == shown_distance) begin
              change_run <= '0;
              state      <= S_IDLE;
            end else if (show_new) begin
              change_run     <= '0;
              shown_distance <= avg_sat;
              state          <= S_DIV_HUN;
            end else begin
              change_run <= change_run_next;
              state      <= S_IDLE;
            end
          end
        end
        S_DIV_HUN: begin
          if (div_rsp.done) begin
            digit_hun <= div_rsp.quotient[DIGIT_W-1:0];
            state     <= S_DIV_TEN;
          end
        end
        S_DIV_TEN: begin
          if (div_rsp.done) begin
            digit_ten  <= div_rsp.quotient[DIGIT_W-1:0];
            digit_unit <= div_rsp.remainder[DIGIT_W-1:0];
            state      <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_data.distance_cm  <= shown_distance;
            out_data.seg_hundreds <= seg_code(digit_hun);
            out_data.seg_tens     <= seg_code(digit_ten) & POINT_MASK;
            out_data.seg_units    <= seg_code(digit_unit);
            state                 <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase

      // Ring write; the last slot of a group starts the summing pass.
      if (store_en) begin
        sample_ring[sample_slot] <= store_val;
        if (sample_slot == SLOT_LAST) begin
          sample_slot <= '0;
          sum_idx     <= '0;
          sum         <= '0;
          state       <= S_SUM;
        end else begin
          sample_slot <= sample_slot + SLOT_W'(1);
          state       <= S_IDLE;
        end
      end
    end
  end

  // Self-checks on the sequencer and the datapath.
  `ASSERT_IMP(a_div_done_in_div_state, clk, rst, div_rsp.done, (state == S_DIV_CM) || (state == S_DIV_AVG) || (state == S_DIV_HUN) || (state == S_DIV_TEN), "divider finished outside a divide state")
  `ASSERT_IMP(a_slot_in_range, clk, rst, 1'b1, sample_slot <= SLOT_LAST, "sample slot beyond the ring")
  `ASSERT_IMP(a_out_in_range, clk, rst, out_valid, out_data.distance_cm <= SHOW_MAX, "shown distance above saturation")
  `ASSERT_NXT(a_accept_starts_work, clk, rst, in_valid && in_ready, state == S_MUL, "accepted beat did not start conversion")

endmodule
